// ----- design/ppc_pkg.sv -----
package ppc_pkg;

	// Block size
	localparam int CHANNELS   = 8;
	localparam int PHASE_BITS = 24;
	localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CNT_W      = $clog2(CHANNELS + 1);

	// Field widths
	localparam int TEMPO_W  = 16;
	localparam int LEVEL_W  = 15;
	localparam int STEP_W   = 24;
	localparam int PLEN_W   = 16;
	localparam int SEED_W   = 32;
	localparam int OUT_W    = 8;
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;

	// Increment arithmetic: x = (step * tempo) >> 12, inc = x / period
	localparam int SCALED_W = STEP_W + TEMPO_W;
	localparam int X_W      = SCALED_W - 12;
	localparam int RECIP_W  = 32;
	localparam int PROD_W   = X_W + RECIP_W;
	localparam int PER_W    = 4;
	localparam int SUM_W    = ((PHASE_BITS > X_W) ? PHASE_BITS : X_W) + 1;
	localparam int NUM_W    = 35;

	// Register map, index = paddr[3:2]
	localparam logic [1:0] REG_PHASE_STEP   = 2'd0;
	localparam logic [1:0] REG_PULSE_LENGTH = 2'd1;
	localparam logic [1:0] REG_RANDOM       = 2'd2;
	localparam logic [1:0] REG_LFSR_SEED    = 2'd3;

	localparam logic [STEP_W-1:0] RST_PHASE_STEP   = STEP_W'(350);
	localparam logic [PLEN_W-1:0] RST_PULSE_LENGTH = PLEN_W'(48);
	localparam logic [SEED_W-1:0] RST_LFSR_SEED    = SEED_W'(1);

	localparam logic [SEED_W-1:0] LFSR_TAPS = 32'h8020_0003;

	// Schmitt thresholds in millivolts
	localparam logic signed [LEVEL_W-1:0] TRIG_HIGH_MV = LEVEL_W'(1000);
	localparam logic signed [LEVEL_W-1:0] TRIG_LOW_MV  = LEVEL_W'(0);

	// floor((2^32-1)/p), p = 1..9; estimate is floor or floor-1 for x < 2^29
	localparam logic [RECIP_W-1:0] RECIP_TBL [1:9] = '{
		32'hFFFF_FFFF / 1, 32'hFFFF_FFFF / 2, 32'hFFFF_FFFF / 3,
		32'hFFFF_FFFF / 4, 32'hFFFF_FFFF / 5, 32'hFFFF_FFFF / 6,
		32'hFFFF_FFFF / 7, 32'hFFFF_FFFF / 8, 32'hFFFF_FFFF / 9
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCALE,
		ST_RUN,
		ST_RSTP,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [STEP_W-1:0] phase_step;
		logic [PLEN_W-1:0] pulse_length;
		logic              random_offsets;
		logic              seed_wr;
		logic [SEED_W-1:0] seed_data;
	} cfg_t;

	typedef struct packed {
		logic            capture;
		logic            scale;
		logic            issue;
		logic            rst_step;
		logic            load_out;
		logic [CH_W-1:0] ch;
	} cmd_t;

	typedef struct packed {
		logic fire;
		logic out_free;
	} sts_t;

	// Channel period 9 - i, period 1 past index 8
	function automatic logic [PER_W-1:0] period_of(input logic [CH_W-1:0] ch);
		logic [PER_W-1:0] p;
		if (32'(ch) < 9) begin
			p = PER_W'(9 - 32'(ch));
		end else begin
			p = PER_W'(1);
		end
		return p;
	endfunction

	function automatic logic [RECIP_W-1:0] recip_of(input logic [CH_W-1:0] ch);
		return RECIP_TBL[period_of(ch)];
	endfunction

	// Galois step, right shift; zero state treated as one
	function automatic logic [SEED_W-1:0] lfsr_step(input logic [SEED_W-1:0] cur);
		logic [SEED_W-1:0] v;
		logic              bit_out;
		v       = (cur == '0) ? SEED_W'(1) : cur;
		bit_out = v[0];
		v       = v >> 1;
		if (bit_out) begin
			v = v ^ LFSR_TAPS;
		end
		return v;
	endfunction

	// Low channels into the 8-bit result fields
	function automatic logic [OUT_W-1:0] to_out(input logic [CHANNELS-1:0] v);
		logic [OUT_W-1:0] r;
		r = '0;
		for (int i = 0; i < OUT_W; i++) begin
			if (i < CHANNELS) begin
				r[i] = v[i];
			end
		end
		return r;
	endfunction

endpackage

// ----- design/polyrhythm_phase_clock.sv -----
// Eight phase-accumulator clock dividers driven by one sample tick per input request.
// Channel i advances by (phase_step * tempo / 4096) / (9 - i) per tick, wraps modulo
// 2^24 and fires a gate of pulse_length ticks; a Schmitt trigger on reset_level
// (rise at 1000 mV, fall at 0 mV) clears the phases or loads LFSR offsets. Each tick
// passes from acceptance to result through capture, the scale multiply, each channel
// in turn through the shared reciprocal multiplier plus a drain step, a phase reload
// per channel when the trigger fires, and the result load once the output register
// is free. The next tick is accepted after that, even while the result still waits
// on the output register. Configure over APB only while no tick is in flight.
module polyrhythm_phase_clock
	import ppc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// APB configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	// tick stream in
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [31:0]       s_axis_tdata,  // [15:0] tempo, [30:16] reset_level, [31] zero
	// result stream out
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [15:0]       m_axis_tdata   // [7:0] gates, [15:8] wrapped
);

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	ppc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ppc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ppc_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (cmd),
		.sts         (sts),
		.tempo       (s_axis_tdata[TEMPO_W-1:0]),
		.reset_level (s_axis_tdata[TEMPO_W+LEVEL_W-1:TEMPO_W]),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_data    (m_axis_tdata)
	);

endmodule

// ----- design/ppc_regs.sv -----
module ppc_regs
	import ppc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [STEP_W-1:0] phase_step_q;
	logic [PLEN_W-1:0] pulse_length_q;
	logic              random_q;
	logic [SEED_W-1:0] seed_q;
	logic              wr_en;
	logic [1:0]        reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel & penable & pwrite & pready;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q   <= RST_PHASE_STEP;
			pulse_length_q <= RST_PULSE_LENGTH;
			random_q       <= 1'b0;
			seed_q         <= RST_LFSR_SEED;
		end else if (wr_en) begin
			case (reg_idx)
				REG_PHASE_STEP:   phase_step_q   <= pwdata[STEP_W-1:0];
				REG_PULSE_LENGTH: pulse_length_q <= pwdata[PLEN_W-1:0];
				REG_RANDOM:       random_q       <= pwdata[0];
				REG_LFSR_SEED:    seed_q         <= pwdata[SEED_W-1:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		case (reg_idx)
			REG_PHASE_STEP:   prdata = DATA_W'(phase_step_q);
			REG_PULSE_LENGTH: prdata = DATA_W'(pulse_length_q);
			REG_RANDOM:       prdata = DATA_W'(random_q);
			REG_LFSR_SEED:    prdata = DATA_W'(seed_q);
			default:          prdata = '0;
		endcase
	end

	// Seed write also reloads the generator
	always_comb begin
		cfg.phase_step     = phase_step_q;
		cfg.pulse_length   = pulse_length_q;
		cfg.random_offsets = random_q;
		cfg.seed_wr        = wr_en && (reg_idx == REG_LFSR_SEED);
		cfg.seed_data      = pwdata[SEED_W-1:0];
	end

endmodule

// ----- design/ppc_ctrl.sv -----
module ppc_ctrl
	import ppc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;

	localparam logic [CNT_W-1:0] LAST_CH = CNT_W'(CHANNELS - 1);
	localparam logic [CNT_W-1:0] RUN_END = CNT_W'(CHANNELS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_SCALE;
				end
			end
			ST_SCALE: begin
				state_d = ST_RUN;
				cnt_d   = '0;
			end
			ST_RUN: begin
				// the count past the last channel drains the last channel update
				if (cnt_q == RUN_END) begin
					cnt_d   = '0;
					state_d = sts.fire ? ST_RSTP : ST_FIN;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_RSTP: begin
				if (cnt_q == LAST_CH) begin
					cnt_d   = '0;
					state_d = ST_FIN;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_FIN: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		in_ready     = 1'b0;
		cmd.capture  = 1'b0;
		cmd.scale    = 1'b0;
		cmd.issue    = 1'b0;
		cmd.rst_step = 1'b0;
		cmd.load_out = 1'b0;
		cmd.ch       = cnt_q[CH_W-1:0];
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_SCALE: cmd.scale    = 1'b1;
			ST_RUN:   cmd.issue    = (cnt_q != RUN_END);
			ST_RSTP:  cmd.rst_step = 1'b1;
			ST_FIN:   cmd.load_out = sts.out_free;
			default: ;
		endcase
	end

endmodule

// ----- design/ppc_dp.sv -----
module ppc_dp
	import ppc_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  cfg_t                      cfg,
	input  cmd_t                      cmd,
	output sts_t                      sts,
	input  logic [TEMPO_W-1:0]        tempo,
	input  logic signed [LEVEL_W-1:0] reset_level,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [2*OUT_W-1:0]        out_data
);

	logic [TEMPO_W-1:0]    tempo_q;
	logic                  trig_high_q;
	logic                  fire_q;
	logic [SCALED_W-1:0]   scaled_q;
	logic [X_W-1:0]        x;
	logic [PROD_W-1:0]     prod_s1;
	logic [CH_W-1:0]       ch_s1;
	logic                  v_s1;
	logic [SEED_W-1:0]     lfsr_q;
	logic [PHASE_BITS-1:0] phase_q [CHANNELS];
	logic [PLEN_W-1:0]     pulse_q [CHANNELS];
	logic [CHANNELS-1:0]   gates_q;
	logic [CHANNELS-1:0]   wraps_q;
	logic                  out_valid_q;
	logic [2*OUT_W-1:0]    out_data_q;

	// Stage 2 signals
	logic [PER_W-1:0]      per;
	logic [X_W-1:0]        q_est;
	logic [X_W:0]          rem;
	logic [X_W-1:0]        inc;
	logic [SUM_W-1:0]      sum;
	logic                  wrap;
	logic [PLEN_W-1:0]     pl_arm;
	logic                  gate;

	// Reset pass signals
	logic [SEED_W-1:0]     lfsr_nx;
	logic [NUM_W-1:0]      num;

	assign x = scaled_q[SCALED_W-1:12];

	// Divide by period: reciprocal estimate, one corrective step
	always_comb begin
		per    = period_of(ch_s1);
		q_est  = prod_s1[PROD_W-1:RECIP_W];
		rem    = {1'b0, x} - (X_W+1)'(q_est * per);
		inc    = q_est + X_W'(rem >= (X_W+1)'(per));
		sum    = SUM_W'(phase_q[ch_s1]) + SUM_W'(inc);
		wrap   = |sum[SUM_W-1:PHASE_BITS];
		pl_arm = (wrap && (cfg.pulse_length > pulse_q[ch_s1])) ? cfg.pulse_length
			: pulse_q[ch_s1];
		gate   = (pl_arm != '0);
	end

	// Random offset (6u + 1) / 8 of a full cycle
	always_comb begin
		lfsr_nx = lfsr_step(lfsr_q);
		num     = {1'b0, lfsr_nx, 2'b00} + {2'b00, lfsr_nx, 1'b0} + (NUM_W'(1) << 32);
	end

	// Input capture and Schmitt trigger
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_high_q <= 1'b0;
			fire_q      <= 1'b0;
		end else if (cmd.capture) begin
			fire_q <= !trig_high_q && (reset_level >= TRIG_HIGH_MV);
			if (trig_high_q) begin
				if (reset_level <= TRIG_LOW_MV) begin
					trig_high_q <= 1'b0;
				end
			end else if (reset_level >= TRIG_HIGH_MV) begin
				trig_high_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			tempo_q <= tempo;
		end
		if (cmd.scale) begin
			scaled_q <= SCALED_W'(cfg.phase_step * tempo_q);
		end
		if (cmd.issue) begin
			prod_s1 <= PROD_W'(x * recip_of(cmd.ch));
			ch_s1   <= cmd.ch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
		end
	end

	// Channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				phase_q[i] <= '0;
				pulse_q[i] <= '0;
			end
			lfsr_q <= RST_LFSR_SEED;
		end else begin
			if (cfg.seed_wr) begin
				lfsr_q <= cfg.seed_data;
			end
			if (v_s1) begin
				phase_q[ch_s1] <= sum[PHASE_BITS-1:0];
				pulse_q[ch_s1] <= pl_arm - PLEN_W'(gate);
			end
			if (cmd.rst_step) begin
				if (cfg.random_offsets && (cmd.ch != '0)) begin
					phase_q[cmd.ch] <= num[NUM_W-1:NUM_W-PHASE_BITS];
					lfsr_q          <= lfsr_nx;
				end else begin
					phase_q[cmd.ch] <= '0;
				end
			end
		end
	end

	// Gate and wrap collection
	always_ff @(posedge clk) begin
		if (cmd.scale) begin
			gates_q <= '0;
			wraps_q <= '0;
		end else if (v_s1) begin
			gates_q[ch_s1] <= gate;
			wraps_q[ch_s1] <= wrap;
		end
	end

	// Output register: holds a result while the next item is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_data_q <= {to_out(wraps_q), to_out(gates_q)};
		end
	end

	assign out_valid    = out_valid_q;
	assign out_data     = out_data_q;
	assign sts.fire     = fire_q;
	assign sts.out_free = !out_valid_q || out_ready;

endmodule
